[rtl/rlid_pkg.sv]
// ----------------------------------------------------------------------------
// rlid_pkg
// Shared types and constants of the RGB run-length image decoder: token
// passed from the byte parser to the run accounting stage, result record,
// identifier bytes and field codes.
// ----------------------------------------------------------------------------
package rlid_pkg;

  localparam int IDENT_LEN   = 8;
  localparam int MAGIC_IDX_W = $clog2(IDENT_LEN);
  localparam int RUN_W       = 12;
  localparam int DIM_W       = 16;
  localparam int PIX_W       = 2 * DIM_W;
  localparam int QUEUE_DEPTH = 4;

  // Count word layout
  localparam int CNT_REPEAT_BIT = 15;
  localparam int CNT_BAD_HI     = 14;
  localparam int CNT_BAD_LO     = 12;

  // Identifier that opens every record
  localparam logic [7:0] MAGIC_BYTES [IDENT_LEN] = '{
    8'h4D, 8'h6F, 8'h74, 8'h6F, 8'h52, 8'h75, 8'h6E, 8'h00
  };

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_IDENT    = 2'd0,
    ERR_COUNT    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_t;

  // Parser phases
  typedef enum logic [3:0] {
    FP_IDENT, FP_WH, FP_WL, FP_HH, FP_HL, FP_CH, FP_CL, FP_PB, FP_PG, FP_PR
  } fphase_t;

  // Accounting stage states
  typedef enum logic [1:0] {
    BK_ACTIVE, BK_DONE, BK_HALTED
  } bstate_t;

  // Token classes
  typedef enum logic [2:0] {
    TOK_NONE, TOK_HEADER, TOK_REPEAT, TOK_LITERAL, TOK_ERROR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic              last;      // token came from the final byte
    logic              boundary;  // parser stands at a count word boundary
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [PIX_W-1:0]  product;   // width * height on header tokens
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [RUN_W-1:0]  run_length;
    err_t              err_code;
  } token_t;

  typedef struct packed {
    kind_t             kind;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [RUN_W-1:0]  run_length;
    err_t              error_code;
    logic              image_full;
    logic              stream_end;
  } result_t;

endpackage

[rtl/rlid_if.sv]
// ----------------------------------------------------------------------------
// rlid_if
// Valid/ready channels of the decoder: the compressed byte stream and the
// decoded result stream.
// ----------------------------------------------------------------------------
interface rlid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface rlid_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] run_length;
  logic [1:0]  error_code;
  logic        image_full;
  logic        stream_end;

  modport source(output valid, kind, image_width, image_height, red, green, blue,
                 run_length, error_code, image_full, stream_end, input ready);
  modport sink(input valid, kind, image_width, image_height, red, green, blue,
               run_length, error_code, image_full, stream_end, output ready);
endinterface

[rtl/rlid_front.sv]
// ----------------------------------------------------------------------------
// rlid_front
// Byte parser: checks the identifier, assembles width, height and count
// words and pixel triples, and passes a token to the run accounting stage for
// each header, run, error or final byte. Image fill level is not tracked here.
// ----------------------------------------------------------------------------
module rlid_front
  import rlid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rlid_byte_if.sink  bytes,
  output logic       tok_valid,
  input  logic       tok_ready,
  output token_t     tok
);

  fphase_t                phase, phase_step, phase_next;
  logic [MAGIC_IDX_W-1:0] magic_idx, magic_idx_next;
  logic [DIM_W-1:0]       width_reg, width_next;
  logic [7:0]             height_hi, height_hi_next;
  logic [7:0]             count_high, count_high_next;
  logic [RUN_W-1:0]       run_left, run_left_next;
  logic                   repeat_mode, repeat_next;
  logic [7:0]             held_blue, held_blue_next;
  logic [7:0]             held_green, held_green_next;
  logic                   halted, halted_next;

  logic                   accept;
  logic [7:0]             b;
  logic [15:0]            count_word;
  logic                   magic_bad;
  logic                   count_bad;

  assign b          = bytes.data_byte;
  assign count_word = {count_high, b};
  assign magic_bad  = (b != MAGIC_BYTES[magic_idx]);
  assign count_bad  = (count_word[CNT_BAD_HI:CNT_BAD_LO] != '0);
  assign accept     = bytes.valid && bytes.ready;
  assign bytes.ready = tok_ready;

  // Next state
  always_comb begin
    phase_step      = phase;
    magic_idx_next  = magic_idx;
    width_next      = width_reg;
    height_hi_next  = height_hi;
    count_high_next = count_high;
    run_left_next   = run_left;
    repeat_next     = repeat_mode;
    held_blue_next  = held_blue;
    held_green_next = held_green;
    halted_next     = halted;
    if (!halted) begin
      unique case (phase)
        FP_IDENT: begin
          if (magic_bad) begin
            halted_next = 1'b1;
          end else begin
            magic_idx_next = magic_idx + 1'b1;
            if (magic_idx == MAGIC_IDX_W'(IDENT_LEN - 1)) phase_step = FP_WH;
          end
        end
        FP_WH: begin
          width_next = {b, 8'h00};
          phase_step = FP_WL;
        end
        FP_WL: begin
          width_next = {width_reg[15:8], b};
          phase_step = FP_HH;
        end
        FP_HH: begin
          height_hi_next = b;
          phase_step     = FP_HL;
        end
        FP_HL: phase_step = FP_CH;
        FP_CH: begin
          count_high_next = b;
          phase_step      = FP_CL;
        end
        FP_CL: begin
          if (count_bad) begin
            halted_next = 1'b1;
          end else begin
            repeat_next   = count_word[CNT_REPEAT_BIT];
            run_left_next = count_word[RUN_W-1:0];
            phase_step    = (count_word[CNT_REPEAT_BIT] || count_word[RUN_W-1:0] != '0)
                            ? FP_PB : FP_CH;
          end
        end
        FP_PB: begin
          held_blue_next = b;
          phase_step     = FP_PG;
        end
        FP_PG: begin
          held_green_next = b;
          phase_step      = FP_PR;
        end
        FP_PR: begin
          if (repeat_mode) begin
            phase_step = FP_CH;
          end else begin
            run_left_next = run_left - 1'b1;
            phase_step    = (run_left == RUN_W'(1)) ? FP_CH : FP_PB;
          end
        end
        default: phase_step = FP_IDENT;
      endcase
    end
    phase_next = phase_step;
    // Final byte restarts the parser
    if (bytes.last_byte) begin
      phase_next     = FP_IDENT;
      magic_idx_next = '0;
      halted_next    = 1'b0;
    end
  end

  // Token
  always_comb begin
    tok            = '0;
    tok.kind       = TOK_NONE;
    tok.err_code   = ERR_IDENT;
    tok.last       = bytes.last_byte;
    tok.boundary   = (phase_step == FP_CH);
    tok.width      = width_reg;
    tok.height     = {height_hi, b};
    tok.product    = PIX_W'(width_reg) * PIX_W'({height_hi, b});
    tok.red        = b;
    tok.green      = held_green;
    tok.blue       = held_blue;
    tok.run_length = RUN_W'(1);
    if (!halted) begin
      unique case (phase)
        FP_IDENT: begin
          if (magic_bad) begin
            tok.kind     = TOK_ERROR;
            tok.err_code = ERR_IDENT;
          end
        end
        FP_HL: tok.kind = TOK_HEADER;
        FP_CL: begin
          if (count_bad) begin
            tok.kind     = TOK_ERROR;
            tok.err_code = ERR_COUNT;
          end
        end
        FP_PR: begin
          if (repeat_mode) begin
            tok.run_length = run_left;
            if (run_left != '0) tok.kind = TOK_REPEAT;
          end else begin
            tok.kind = TOK_LITERAL;
          end
        end
        default: tok.kind = TOK_NONE;
      endcase
    end
    tok_valid = bytes.valid && (tok.kind != TOK_NONE || bytes.last_byte);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= FP_IDENT;
      magic_idx <= '0;
      halted    <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      magic_idx <= magic_idx_next;
      halted    <= halted_next;
    end
  end

  // Field registers
  always_ff @(posedge clk) begin
    if (accept) begin
      width_reg   <= width_next;
      height_hi   <= height_hi_next;
      count_high  <= count_high_next;
      run_left    <= run_left_next;
      repeat_mode <= repeat_next;
      held_blue   <= held_blue_next;
      held_green  <= held_green_next;
    end
  end

endmodule

[rtl/rlid_queue.sv]
// ----------------------------------------------------------------------------
// rlid_queue
// Small token FIFO between the parser and the accounting stage.
// ----------------------------------------------------------------------------
module rlid_queue
  import rlid_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  token_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output token_t pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  token_t            entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              push, pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

[rtl/rlid_back.sv]
// ----------------------------------------------------------------------------
// rlid_back
// Run accounting: keeps the count of pixels still due, checks runs against
// it, decides clean end or truncation on the final byte, and drives the
// registered result port.
// ----------------------------------------------------------------------------
module rlid_back
  import rlid_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  token_t        tok,
  rlid_result_if.source results
);

  bstate_t          state, state_next;
  logic [PIX_W-1:0] pixels_left, pixels_left_next;
  logic [PIX_W-1:0] remain;
  logic             is_run, over, err_now, done_now, pop, emit;
  logic             res_valid;
  result_t          res_q, res_n;

  assign is_run   = (tok.kind == TOK_REPEAT) || (tok.kind == TOK_LITERAL);
  assign over     = PIX_W'(tok.run_length) > pixels_left;
  assign remain   = pixels_left - PIX_W'(tok.run_length);
  assign err_now  = (tok.kind == TOK_ERROR) || (is_run && over);
  // Image counts as done only when the parser also sits at a word boundary;
  // a literal group that overruns the image keeps decoding and errors later
  assign done_now = ((tok.kind == TOK_HEADER) && tok.product == '0) ||
                    (is_run && !over && remain == '0 && tok.boundary);

  assign tok_ready = !res_valid || results.ready;
  assign pop       = tok_valid && tok_ready;

  // Next state
  always_comb begin
    state_next       = state;
    pixels_left_next = pixels_left;
    if (state == BK_ACTIVE) begin
      if (tok.kind == TOK_HEADER) pixels_left_next = tok.product;
      else if (is_run && !over) pixels_left_next = remain;
      if (err_now)       state_next = BK_HALTED;
      else if (done_now) state_next = BK_DONE;
    end
    if (tok.last) begin
      state_next       = BK_ACTIVE;
      pixels_left_next = '0;
    end
  end

  // Result
  always_comb begin
    res_n            = '0;
    res_n.kind       = KIND_END;
    res_n.error_code = ERR_IDENT;
    res_n.stream_end = tok.last;
    emit             = 1'b0;
    unique case (state)
      BK_HALTED: emit = 1'b0;
      BK_DONE:   emit = tok.last;
      BK_ACTIVE: begin
        unique case (tok.kind)
          TOK_HEADER: begin
            emit               = 1'b1;
            res_n.kind         = KIND_HEADER;
            res_n.image_width  = tok.width;
            res_n.image_height = tok.height;
          end
          TOK_REPEAT, TOK_LITERAL: begin
            emit = 1'b1;
            if (over) begin
              res_n.kind       = KIND_ERROR;
              res_n.error_code = ERR_OVERFLOW;
            end else begin
              res_n.kind       = KIND_RUN;
              res_n.red        = tok.red;
              res_n.green      = tok.green;
              res_n.blue       = tok.blue;
              res_n.run_length = tok.run_length;
              res_n.image_full = (remain == '0);
            end
          end
          TOK_ERROR: begin
            emit             = 1'b1;
            res_n.kind       = KIND_ERROR;
            res_n.error_code = tok.err_code;
          end
          default: emit = 1'b0;
        endcase
        // Final byte: clean end or truncation unless an error was raised
        if (tok.last && !err_now) begin
          if (!(tok.boundary || done_now)) begin
            res_n            = '0;
            res_n.kind       = KIND_ERROR;
            res_n.error_code = ERR_TRUNC;
            res_n.stream_end = 1'b1;
          end else if (!emit) begin
            res_n.kind = KIND_END;
          end
          emit = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_ACTIVE;
      pixels_left <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        state       <= state_next;
        pixels_left <= pixels_left_next;
        res_valid   <= emit;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop) res_q <= res_n;
  end

  assign results.valid        = res_valid;
  assign results.kind         = res_q.kind;
  assign results.image_width  = res_q.image_width;
  assign results.image_height = res_q.image_height;
  assign results.red          = res_q.red;
  assign results.green        = res_q.green;
  assign results.blue         = res_q.blue;
  assign results.run_length   = res_q.run_length;
  assign results.error_code   = res_q.error_code;
  assign results.image_full   = res_q.image_full;
  assign results.stream_end   = res_q.stream_end;

endmodule

[rtl/rgb_run_length_image_decoder.sv]
// ----------------------------------------------------------------------------
// rgb_run_length_image_decoder
// Decodes a run-length compressed 24-bit image record into header, pixel
// run, end and error results.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle unless its FIFO is full, and gives at
// most one result per byte. A byte parser checks the 8-byte identifier,
// assembles the big-endian width, height and count words and the BGR triples,
// and computes width times height with one 16x16 multiplier; its tokens go
// through a small FIFO (QueueDepth entries, at least 2) to the accounting
// stage, which keeps the pixels still due in one 32-bit subtract and compare
// per token and drives a registered result port. A byte's token is stored in
// the FIFO and its result in the result register; the FIFO lets the parser
// keep taking bytes while a result waits on the output. The decoder restarts
// after every byte marked last; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rgb_run_length_image_decoder
  import rlid_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  rlid_byte_if.sink     bytes,
  rlid_result_if.source results
);

  token_t front_tok, back_tok;
  logic   front_valid, front_ready;
  logic   back_valid, back_ready;

  rlid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .tok_valid (front_valid),
    .tok_ready (front_ready),
    .tok       (front_tok)
  );

  rlid_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_tok)
  );

  rlid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (back_valid),
    .tok_ready (back_ready),
    .tok       (back_tok),
    .results   (results)
  );

endmodule

[tb/tb_rgb_run_length_image_decoder.sv]
// ----------------------------------------------------------------------------
// tb_rgb_run_length_image_decoder
// Self-checking bench for the run-length image decoder. Compressed records
// are streamed in one byte per transfer with random gaps on both channels.
// A bit-accurate decode of each accepted byte predicts the result it causes.
// Results are checked in order, field by field. Stimulus is a few directed
// records, then random images with random run content, plus truncated,
// misidentified and noise records. One long output stall fills the decoder
// and backs up the byte channel.
// ----------------------------------------------------------------------------
module tb_rgb_run_length_image_decoder;
  import rlid_pkg::*;

  localparam int          RandomBytes = 1500;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldStart   = 400;   // long output stall begins here
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CalmFrom    = 1200;  // window with no gaps on either side
  localparam int unsigned CalmTo      = 1700;
  localparam int          IdlePct     = 38;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rec_byte_t;

  // Decoder phases as seen by the predictor
  typedef enum logic [3:0] {
    ST_IDENT, ST_WID_HI, ST_WID_LO, ST_HGT_HI, ST_HGT_LO,
    ST_CNT_HI, ST_CNT_LO, ST_BLUE, ST_GREEN, ST_RED, ST_DONE
  } dec_state_t;

  logic clk;
  logic rst;

  rlid_byte_if   byte_ch ();
  rlid_result_if res_ch ();

  rgb_run_length_image_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (res_ch)
  );

  // Stimulus and scoreboard storage
  rec_byte_t   pending_bytes[$];
  logic [7:0]  record_buf[$];
  result_t     due_results[$];
  int          bytes_total;
  int          bytes_taken;
  int          mismatches;
  int unsigned cyc;
  int unsigned hold_left;
  logic        calm;

  assign calm = (cyc >= CalmFrom) && (cyc < CalmTo);

  // Predictor state
  dec_state_t  dec_state;
  logic [3:0]  magic_pos;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [31:0] pix_left;
  logic [7:0]  cnt_hi;
  logic [11:0] run_left;
  logic        run_repeat;
  logic [7:0]  held_b;
  logic [7:0]  held_g;
  logic        stopped;

  task automatic clear_decoder();
    dec_state  = ST_IDENT;
    magic_pos  = '0;
    img_w      = '0;
    img_h      = '0;
    pix_left   = '0;
    cnt_hi     = '0;
    run_left   = '0;
    run_repeat = 1'b0;
    held_b     = '0;
    held_g     = '0;
    stopped    = 1'b0;
  endtask

  // Advance the predictor by one byte; flags whether a result is due
  task automatic decode_byte(input logic [7:0] b, input logic last,
                             output logic has_res, output result_t r);
    logic        fail;
    logic [15:0] cnt;
    r       = '0;
    has_res = 1'b0;
    fail    = 1'b0;
    if (stopped) begin
      if (last) clear_decoder();
      return;
    end
    case (dec_state)
      ST_IDENT: begin
        if (b != MAGIC_BYTES[magic_pos[2:0]]) begin
          fail         = 1'b1;
          r.error_code = ERR_IDENT;
        end else begin
          magic_pos = magic_pos + 4'd1;
          if (magic_pos >= 4'(IDENT_LEN)) dec_state = ST_WID_HI;
        end
      end
      ST_WID_HI: begin
        img_w     = {b, 8'h00};
        dec_state = ST_WID_LO;
      end
      ST_WID_LO: begin
        img_w[7:0] = b;
        dec_state  = ST_HGT_HI;
      end
      ST_HGT_HI: begin
        img_h     = {b, 8'h00};
        dec_state = ST_HGT_LO;
      end
      ST_HGT_LO: begin
        img_h[7:0]     = b;
        pix_left       = {16'd0, img_w} * {16'd0, img_h};
        r.kind         = KIND_HEADER;
        r.image_width  = img_w;
        r.image_height = img_h;
        has_res        = 1'b1;
        dec_state      = (pix_left != 0) ? ST_CNT_HI : ST_DONE;
      end
      ST_CNT_HI: begin
        cnt_hi    = b;
        dec_state = ST_CNT_LO;
      end
      ST_CNT_LO: begin
        cnt = {cnt_hi, b};
        if (cnt[CNT_BAD_HI:CNT_BAD_LO] != '0) begin
          fail         = 1'b1;
          r.error_code = ERR_COUNT;
        end else begin
          run_repeat = cnt[CNT_REPEAT_BIT];
          run_left   = cnt[RUN_W-1:0];
          dec_state  = (run_repeat || run_left != 0) ? ST_BLUE : ST_CNT_HI;
        end
      end
      ST_BLUE: begin
        held_b    = b;
        dec_state = ST_GREEN;
      end
      ST_GREEN: begin
        held_g    = b;
        dec_state = ST_RED;
      end
      ST_RED: begin
        if (run_repeat) begin
          if ({20'd0, run_left} > pix_left) begin
            fail         = 1'b1;
            r.error_code = ERR_OVERFLOW;
          end else if (run_left == 0) begin
            // empty repeat run: triple consumed silently
            dec_state = ST_CNT_HI;
          end else begin
            pix_left     = pix_left - {20'd0, run_left};
            r.kind       = KIND_RUN;
            r.red        = b;
            r.green      = held_g;
            r.blue       = held_b;
            r.run_length = run_left;
            r.image_full = (pix_left == 0);
            has_res      = 1'b1;
            dec_state    = (pix_left != 0) ? ST_CNT_HI : ST_DONE;
          end
        end else begin
          if (pix_left == 0) begin
            fail         = 1'b1;
            r.error_code = ERR_OVERFLOW;
          end else begin
            pix_left     = pix_left - 32'd1;
            run_left     = run_left - 12'd1;
            r.kind       = KIND_RUN;
            r.red        = b;
            r.green      = held_g;
            r.blue       = held_b;
            r.run_length = 12'd1;
            r.image_full = (pix_left == 0);
            has_res      = 1'b1;
            if (run_left == 0) dec_state = (pix_left != 0) ? ST_CNT_HI : ST_DONE;
            else dec_state = ST_BLUE;
          end
        end
      end
      default: ;  // image full: byte ignored
    endcase

    if (fail) begin
      r.kind  = KIND_ERROR;
      has_res = 1'b1;
      stopped = 1'b1;
    end

    // Final byte: clean end only at a count word boundary or a full image
    if (last) begin
      if (!fail) begin
        if (dec_state != ST_CNT_HI && dec_state != ST_DONE) begin
          r            = '0;
          r.kind       = KIND_ERROR;
          r.error_code = ERR_TRUNC;
        end else if (!has_res) begin
          r.kind = KIND_END;
        end
        has_res = 1'b1;
      end
      r.stream_end = 1'b1;
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Record construction
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_word(input logic [15:0] w);
    record_buf.push_back(w[15:8]);
    record_buf.push_back(w[7:0]);
  endtask

  task automatic put_pixel();
    repeat (3) record_buf.push_back(pick_byte());
  endtask

  task automatic put_magic();
    for (int i = 0; i < IDENT_LEN; i++) record_buf.push_back(MAGIC_BYTES[i]);
  endtask

  // Move the first keep bytes of the record into the send queue, last flag on the final one
  task automatic emit_record(input int keep);
    for (int i = 0; i < keep; i++) pending_bytes.push_back({record_buf[i], i == keep - 1});
    record_buf.delete();
  endtask

  // Well-formed image with random runs; some words break the count or overflow
  task automatic build_image();
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] left;
    int          words;
    int          sel;
    int          n;
    int          cap;
    put_magic();
    case ($urandom_range(0, 15))
      0:       begin w = 16'd0;          h = 16'($urandom); end
      1:       begin w = 16'($urandom);  h = 16'd0;         end
      2:       begin w = 16'hFFFF;       h = 16'd1;         end
      3:       begin w = 16'd1;          h = 16'hFFFF;      end
      4:       begin w = 16'hFFFF;       h = 16'hFFFF;      end
      default: begin w = 16'($urandom_range(1, 6)); h = 16'($urandom_range(1, 6)); end
    endcase
    put_word(w);
    put_word(h);
    left  = {16'd0, w} * {16'd0, h};
    words = 0;
    while (left != 0 && words < 20) begin
      words++;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        // reserved count bits set
        put_word({1'($urandom), 3'($urandom_range(1, 7)), 12'($urandom)});
        return;
      end else if (sel < 8) begin
        put_word(16'h8000);
        put_pixel();
      end else if (sel < 12) begin
        put_word(16'h0000);
      end else if (sel < 15 && left < 32'd4095) begin
        // repeat run one longer than the pixels still due
        put_word(16'h8000 | 16'(left + 1));
        put_pixel();
        return;
      end else if (sel < 60) begin
        if (left > 32'd4095) n = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(1, 4095);
        else n = $urandom_range(1, int'(left));
        put_word(16'h8000 | 16'(n));
        put_pixel();
        left = left - 32'(n);
      end else begin
        // literal pixels, now and then one more than fits
        cap = (left < 32'd5) ? int'(left) : 5;
        n   = $urandom_range(1, cap + 1);
        put_word(16'(n));
        repeat (n) put_pixel();
        if (32'(n) > left) return;
        left = left - 32'(n);
      end
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) record_buf.push_back(pick_byte());
  endtask

  // Identifier good up to a random byte, then a wrong one and some trailing bytes
  task automatic build_bad_magic();
    int k;
    k = $urandom_range(0, IDENT_LEN - 1);
    for (int i = 0; i < k; i++) record_buf.push_back(MAGIC_BYTES[i]);
    record_buf.push_back(MAGIC_BYTES[k] ^ 8'($urandom_range(1, 255)));
    repeat ($urandom_range(0, 4)) record_buf.push_back(pick_byte());
  endtask

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d size=%0dx%0d rgb=%02h_%02h_%02h run=%0d err=%0d full=%0b end=%0b",
                     r.kind, r.image_width, r.image_height, r.red, r.green, r.blue,
                     r.run_length, r.error_code, r.image_full, r.stream_end);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = 8'h00;
    byte_ch.last_byte  = 1'b0;
    res_ch.ready       = 1'b0;
    bytes_taken        = 0;
    mismatches         = 0;
    clear_decoder();

    // Directed: empty image ending on its header, bad first byte, one full pixel
    put_magic();
    put_word(16'hFFFF);
    put_word(16'h0000);
    emit_record(record_buf.size());
    record_buf.push_back(8'hFF);
    emit_record(1);
    put_magic();
    put_word(16'h0001);
    put_word(16'h0001);
    put_word(16'h8001);
    record_buf.push_back(8'h00);
    record_buf.push_back(8'hFF);
    record_buf.push_back(8'hA5);
    emit_record(record_buf.size());

    // Random records, mostly well-formed
    while (pending_bytes.size() < RandomBytes + 32) begin
      case ($urandom_range(0, 9))
        7: begin
          build_image();
          emit_record($urandom_range(1, record_buf.size()));
        end
        8: begin
          build_bad_magic();
          emit_record(record_buf.size());
        end
        9: begin
          repeat ($urandom_range(1, 12)) record_buf.push_back(8'($urandom));
          emit_record(record_buf.size());
        end
        default: begin
          build_image();
          emit_record(record_buf.size());
        end
      endcase
    end
    bytes_total = pending_bytes.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != bytes_total) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    mismatches = mismatches + due_results.size();
    if (mismatches == 0) begin
      $display("[rgb_run_length_image_decoder] OK");
    end else begin
      $display("[rgb_run_length_image_decoder] ERROR");
    end
    $finish;
  end

  // Cycle count and watchdog
  initial cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("[rgb_run_length_image_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte driver: predicts on each transfer, then offers the next byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    rec_byte_t nxt;
    result_t   pred;
    logic      pred_ok;
    logic      offer;
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.data_byte, byte_ch.last_byte, pred_ok, pred);
        if (pred_ok) due_results.push_back(pred);
        bytes_taken <= bytes_taken + 1;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        // keep offering through the output stall so the decoder backs up
        offer = (pending_bytes.size() != 0) &&
                (calm || hold_left != 0 || $urandom_range(0, 99) >= IdlePct);
        if (offer) begin
          nxt = pending_bytes.pop_front();
          byte_ch.data_byte <= nxt.data;
          byte_ch.last_byte <= nxt.last;
        end
        byte_ch.valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (cyc == HoldStart) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HoldCycles;
    end else if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    logic    same;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.kind         = kind_t'(res_ch.kind);
      seen.image_width  = res_ch.image_width;
      seen.image_height = res_ch.image_height;
      seen.red          = res_ch.red;
      seen.green        = res_ch.green;
      seen.blue         = res_ch.blue;
      seen.run_length   = res_ch.run_length;
      seen.error_code   = err_t'(res_ch.error_code);
      seen.image_full   = res_ch.image_full;
      seen.stream_end   = res_ch.stream_end;
      if (due_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result: %s", show(seen));
      end else begin
        want = due_results.pop_front();
        same = (seen.kind === want.kind) &&
               (seen.image_width === want.image_width) &&
               (seen.image_height === want.image_height) &&
               (seen.red === want.red) &&
               (seen.green === want.green) &&
               (seen.blue === want.blue) &&
               (seen.run_length === want.run_length) &&
               (seen.error_code === want.error_code) &&
               (seen.image_full === want.image_full) &&
               (seen.stream_end === want.stream_end);
        if (!same) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("result mismatch at cycle %0d", cyc);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(seen));
          end
        end
      end
    end
  end

endmodule
